// File: src/threshold_rate_search_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the threshold search checker.
// ----------------------------------------------------------------------------
`ifndef THRESHOLD_RATE_SEARCH_MACROS_SVH
`define THRESHOLD_RATE_SEARCH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TRS_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("threshold_rate_search: check failed");

// Next-cycle implication, disabled during reset.
`define TRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("threshold_rate_search: check failed");

`endif

// File: src/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Types and constants of the threshold rate search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package trs_pkg;

  localparam int THR_W  = 12;
  localparam int RATE_W = 32;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int DIV_CNT_W   = 5;

  localparam logic [25:0] RATE_CLOCK_HZ = 26'd50000000;
  localparam logic [3:0]  ZERO_LIMIT_SCAN     = 4'd15;
  localparam logic [3:0]  ZERO_LIMIT_FALLBACK = 4'd3;
  localparam logic [THR_W-1:0] THR_MAX = '1;
  localparam logic [RATE_W-1:0] RATE_SAT = '1;
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = '1;

  // Register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_RATE_GOAL   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_THR = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_START  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_END    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_SCAN_STEP   = 3'd4;

  // Register reset values.
  localparam logic [RATE_W-1:0] RATE_GOAL_RST   = 32'd1000;
  localparam logic [THR_W-1:0]  INITIAL_THR_RST = 12'd320;
  localparam logic [THR_W-1:0]  SCAN_START_RST  = 12'd0;
  localparam logic [THR_W-1:0]  SCAN_END_RST    = 12'd4095;
  localparam logic [THR_W-1:0]  SCAN_STEP_RST   = 12'd16;

  // Result status codes.
  localparam logic [1:0] STATUS_CONTINUE  = 2'd0;
  localparam logic [1:0] STATUS_CROSSED   = 2'd1;
  localparam logic [1:0] STATUS_FELL_BACK = 2'd2;
  localparam logic [1:0] STATUS_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [31:0] event_count;
    logic [31:0] time_count;
  } trs_in_t;

  typedef struct packed {
    logic [THR_W-1:0]  next_threshold;
    logic [RATE_W-1:0] measured_rate;
    logic [1:0]        status;
  } trs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_UPDATE
  } trs_state_t;

  typedef struct packed {
    logic load_in;
    logic mul;
    logic prep;
    logic div_step;
    logic commit;
  } trs_cmd_t;

  typedef struct packed {
    logic sat_now;
    logic out_free;
  } trs_stat_t;

endpackage

// File: src/trs_ctrl.sv
// ----------------------------------------------------------------------------
// trs_ctrl
// Sequencer: capture, multiply, divide setup, 32 divide steps unless the rate saturates, update.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  trs_pkg::trs_stat_t stat,
  output trs_pkg::trs_cmd_t  cmd
);
  import trs_pkg::*;

  trs_state_t state, state_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    in_ready     = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.prep     = 1'b1;
        div_cnt_next = '0;
        // A quotient that cannot fit in 32 bits skips the divider.
        state_next   = stat.sat_now ? ST_UPDATE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_next = div_cnt + 1'b1;
        if (div_cnt == DIV_LAST) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/trs_dp.sv
// ----------------------------------------------------------------------------
// trs_dp
// Datapath: configuration registers, rate multiply and serial divide,
// search state and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module trs_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  trs_pkg::trs_in_t                    in_data,
  input  logic                                cfg_we,
  input  logic [trs_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  trs_pkg::trs_cmd_t                   cmd,
  output trs_pkg::trs_stat_t                  stat,
  output logic                                out_valid,
  input  logic                                out_ready,
  output trs_pkg::trs_out_t                   out_data
);
  import trs_pkg::*;

  // Configuration.
  logic [RATE_W-1:0] rate_goal;
  logic [THR_W-1:0]  initial_thr;
  logic [THR_W-1:0]  scan_start;
  logic [THR_W-1:0]  scan_end;
  logic [THR_W-1:0]  scan_step;

  // Rate arithmetic.
  logic [31:0] event_count;
  logic [31:0] time_count;
  logic [63:0] prod;
  logic [31:0] rem;
  logic [31:0] quo;
  logic        sat;
  logic [32:0] trial;
  logic [RATE_W-1:0] rate;

  // Search state.
  logic [THR_W-1:0]  cur_thr, cur_thr_next;
  logic [THR_W-1:0]  prior_thr, prior_thr_next;
  logic [RATE_W-1:0] prior_rate, prior_rate_next;
  logic              prior_valid, prior_valid_next;
  logic [3:0]        zero_run, zero_run_next;
  logic [THR_W-1:0]  fb_thr, fb_thr_next;
  logic [RATE_W-1:0] fb_rate, fb_rate_next;
  logic              scanning, scanning_next;
  trs_out_t          result;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_goal   <= RATE_GOAL_RST;
      initial_thr <= INITIAL_THR_RST;
      scan_start  <= SCAN_START_RST;
      scan_end    <= SCAN_END_RST;
      scan_step   <= SCAN_STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RATE_GOAL:   rate_goal   <= cfg_data;
        REG_INITIAL_THR: initial_thr <= cfg_data[THR_W-1:0];
        REG_SCAN_START:  scan_start  <= cfg_data[THR_W-1:0];
        REG_SCAN_END:    scan_end    <= cfg_data[THR_W-1:0];
        REG_SCAN_STEP:   scan_step   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // The quotient overflows 32 bits exactly when the upper product half is not
  // below the divisor; a zero time count falls in that case as well.
  assign stat.sat_now  = (prod[63:32] >= time_count);
  assign stat.out_free = !out_valid || out_ready;

  assign trial = {rem, quo[31]} - {1'b0, time_count};
  assign rate  = sat ? RATE_SAT : quo;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      event_count <= in_data.event_count;
      time_count  <= in_data.time_count;
    end
    if (cmd.mul) begin
      prod <= 64'(58'(event_count) * 58'(RATE_CLOCK_HZ));
    end
    if (cmd.prep) begin
      rem <= prod[63:32];
      quo <= prod[31:0];
      sat <= stat.sat_now;
    end else if (cmd.div_step) begin
      // Restoring division, one quotient bit per cycle.
      if (!trial[32]) begin
        rem <= trial[31:0];
      end else begin
        rem <= {rem[30:0], quo[31]};
      end
      quo <= {quo[30:0], !trial[32]};
    end
  end

  always_comb begin
    logic [THR_W-1:0]  thr;
    logic [RATE_W-1:0] r;
    logic              finish;
    logic              was_low;
    logic              is_low;

    thr    = cur_thr;
    r      = rate;
    finish = 1'b0;
    was_low = 1'b0;
    is_low  = 1'b0;

    cur_thr_next     = cur_thr;
    prior_thr_next   = prior_thr;
    prior_rate_next  = prior_rate;
    prior_valid_next = prior_valid;
    zero_run_next    = zero_run;
    fb_thr_next      = fb_thr;
    fb_rate_next     = fb_rate;
    scanning_next    = scanning;
    result           = '0;

    if (scanning && (({1'b0, cur_thr} + {1'b0, scan_step}) > {1'b0, scan_end})) begin
      finish = 1'b1;
      result.next_threshold = initial_thr;
      result.measured_rate  = '0;
      result.status         = STATUS_EXHAUSTED;
    end else begin
      if (rate == '0) begin
        if (!scanning) begin
          zero_run_next = zero_run + 1'b1;
        end
        if (fb_thr == '0) begin
          if (zero_run_next == ZERO_LIMIT_SCAN) begin
            scanning_next = 1'b1;
            thr           = scan_start - scan_step;
            zero_run_next = '0;
          end
        end else if (zero_run_next == ZERO_LIMIT_FALLBACK) begin
          finish = 1'b1;
          result.next_threshold = fb_thr;
          result.measured_rate  = fb_rate;
          result.status         = STATUS_FELL_BACK;
        end
      end else begin
        if (!scanning) begin
          fb_thr_next   = cur_thr;
          fb_rate_next  = rate;
          zero_run_next = '0;
        end else begin
          scanning_next = 1'b0;
        end
      end

      if (!finish) begin
        was_low = (prior_rate <= rate_goal);
        is_low  = (rate <= rate_goal);
        if (prior_valid && (was_low != is_low)) begin
          // Crossed the target: keep the lower of the two thresholds.
          if (thr > prior_thr) begin
            thr = prior_thr;
            r   = prior_rate;
          end
          finish = 1'b1;
          result.next_threshold = thr;
          result.measured_rate  = r;
          result.status         = STATUS_CROSSED;
        end else begin
          prior_thr_next   = thr;
          prior_rate_next  = rate;
          prior_valid_next = 1'b1;
          if (!scanning_next) begin
            if (rate > rate_goal) begin
              if (thr != '0) begin
                thr = thr - 1'b1;
              end
            end else if (thr != THR_MAX) begin
              thr = thr + 1'b1;
            end
          end else begin
            thr = thr + scan_step;
          end
          cur_thr_next          = thr;
          result.next_threshold = thr;
          result.measured_rate  = rate;
          result.status         = STATUS_CONTINUE;
        end
      end
    end

    if (finish) begin
      cur_thr_next     = initial_thr;
      prior_thr_next   = initial_thr;
      prior_rate_next  = '0;
      prior_valid_next = 1'b0;
      zero_run_next    = '0;
      fb_thr_next      = '0;
      fb_rate_next     = '0;
      scanning_next    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_thr     <= INITIAL_THR_RST;
      prior_thr   <= INITIAL_THR_RST;
      prior_rate  <= '0;
      prior_valid <= 1'b0;
      zero_run    <= '0;
      fb_thr      <= '0;
      fb_rate     <= '0;
      scanning    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        cur_thr     <= cur_thr_next;
        prior_thr   <= prior_thr_next;
        prior_rate  <= prior_rate_next;
        prior_valid <= prior_valid_next;
        zero_run    <= zero_run_next;
        fb_thr      <= fb_thr_next;
        fb_rate     <= fb_rate_next;
        scanning    <= scanning_next;
        out_valid   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= result;
    end
  end

endmodule

// File: src/threshold_rate_search.sv
// ----------------------------------------------------------------------------
// threshold_rate_search
// Discriminator threshold search driven by measured hit rates.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one item: an event count and the 50 MHz tick count
//   of its window. out_valid/out_ready return one result item per input item:
//   the threshold to apply, the measured or chosen rate, and a status code.
//   cfg_we writes cfg_data into register cfg_index. The user must see that it
//   is used only while the block is idle; the block does not enforce this.
// Sequence:
//   An accepted item passes a multiply step, a divider setup step, the
//   restoring divider (one quotient bit per cycle) and an update step that
//   writes the output register. When the rate saturates the divider is
//   skipped. One item is in work at a time and the next one is taken in the
//   cycle after the update.
// Reset and stalls:
//   Reset loads the register defaults and restarts the search from the
//   initial threshold. A result waits in the output register while out_ready
//   is low; the next item is still accepted and computed, and its update
//   waits until the output register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module threshold_rate_search (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  trs_pkg::trs_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output trs_pkg::trs_out_t               out_data,
  input  logic                            cfg_we,
  input  logic [trs_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [trs_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import trs_pkg::*;

  trs_cmd_t  cmd;
  trs_stat_t stat;

  trs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  trs_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: src/trs_checker.sv
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks of the threshold search block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "threshold_rate_search_macros.svh"

module trs_checker (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input trs_pkg::trs_in_t  in_data,
  input logic              out_valid,
  input logic              out_ready,
  input trs_pkg::trs_out_t out_data
);
  import trs_pkg::*;

  // An offered item stays offered and unchanged until it is taken.
  `TRS_ASSERT_NEXT(a_in_hold, clk, rst, in_valid && !in_ready, in_valid && $stable(in_data))

  // A result that is held back keeps its value.
  `TRS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data))

  // One item at a time: the block is busy right after taking an item.
  `TRS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)

  // A failed scan reports a zero rate.
  `TRS_ASSERT_NOW(a_exhausted_rate, clk, rst, out_valid && (out_data.status == STATUS_EXHAUSTED), out_data.measured_rate == '0)

endmodule

bind threshold_rate_search trs_checker u_trs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/threshold_rate_search_test.sv
// ----------------------------------------------------------------------------
// threshold_rate_search_test
// Self-checking bench for the discriminator threshold search. A driver and a
// monitor run from clocked processes; the monitor predicts every result from
// its own copy of the search state and checks each returned item field by
// field. Directed windows cover saturation, fallback, scan wrap and scan
// exhaustion; random search episodes follow under varied register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module threshold_rate_search_test;
  import trs_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 100;
  localparam int PHASES = 16;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  trs_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  trs_out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  threshold_rate_search DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register copies used by the predictor.
  logic [RATE_W-1:0] rate_goal_cfg = RATE_GOAL_RST;
  logic [THR_W-1:0] initial_thr_cfg = INITIAL_THR_RST;
  logic [THR_W-1:0] scan_start_cfg = SCAN_START_RST;
  logic [THR_W-1:0] scan_end_cfg = SCAN_END_RST;
  logic [THR_W-1:0] scan_step_cfg = SCAN_STEP_RST;

  // Search state as the predictor tracks it.
  logic [THR_W-1:0] thr_now = INITIAL_THR_RST;
  logic [THR_W-1:0] thr_prev = INITIAL_THR_RST;
  logic [RATE_W-1:0] rate_prev = '0;
  logic rate_prev_ok = 1'b0;
  logic [3:0] zero_count = '0;
  logic [THR_W-1:0] fallback_thr = '0;
  logic [RATE_W-1:0] fallback_rate = '0;
  logic in_scan = 1'b0;

  trs_in_t pending_items[$];
  trs_out_t results_due[$];
  trs_out_t due_result;

  int items_queued = 0;
  int items_offered = 0;
  int items_accepted = 0;
  int results_taken = 0;
  int results_counted = 0;
  int mismatch_count = 0;
  int cycle_count = 0;
  int send_wait = 0;
  int take_wait = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit send_quiet = 1'b0;
  bit take_quiet = 1'b0;

  function automatic logic [RATE_W-1:0] hit_rate(input logic [31:0] count,
                                                 input logic [31:0] ticks);
    logic [63:0] quotient;
    if (ticks == 0) return RATE_SAT;
    quotient = ({32'd0, count} * {38'd0, RATE_CLOCK_HZ}) / {32'd0, ticks};
    if (quotient[63:32] != 0) return RATE_SAT;
    return quotient[31:0];
  endfunction

  function automatic void begin_new_search();
    thr_now = initial_thr_cfg;
    thr_prev = initial_thr_cfg;
    rate_prev = '0;
    rate_prev_ok = 1'b0;
    zero_count = '0;
    fallback_thr = '0;
    fallback_rate = '0;
    in_scan = 1'b0;
  endfunction

  function automatic trs_out_t close_search(input logic [THR_W-1:0] thr,
                                            input logic [RATE_W-1:0] rate,
                                            input logic [1:0] code);
    trs_out_t res;
    res.next_threshold = thr;
    res.measured_rate = rate;
    res.status = code;
    begin_new_search();
    return res;
  endfunction

  function automatic trs_out_t next_search_result(input trs_in_t it);
    logic [RATE_W-1:0] rate;
    logic [THR_W-1:0] thr;
    logic was_low;
    logic is_low;
    trs_out_t res;
    rate = hit_rate(it.event_count, it.time_count);
    thr = thr_now;
    // The exhaustion test uses the sum without wrap.
    if (in_scan && ({1'b0, thr} + {1'b0, scan_step_cfg} > {1'b0, scan_end_cfg}))
      return close_search(initial_thr_cfg, '0, STATUS_EXHAUSTED);
    if (rate == 0) begin
      if (!in_scan) zero_count = zero_count + 4'd1;
      if (fallback_thr == 0) begin
        if (zero_count == ZERO_LIMIT_SCAN) begin
          in_scan = 1'b1;
          thr = scan_start_cfg - scan_step_cfg;
          zero_count = '0;
        end
      end else if (zero_count == ZERO_LIMIT_FALLBACK) begin
        return close_search(fallback_thr, fallback_rate, STATUS_FELL_BACK);
      end
    end else if (!in_scan) begin
      fallback_thr = thr;
      fallback_rate = rate;
      zero_count = '0;
    end else begin
      in_scan = 1'b0;
    end
    if (rate_prev_ok) begin
      was_low = rate_prev <= rate_goal_cfg;
      is_low = rate <= rate_goal_cfg;
      if (was_low != is_low) begin
        if (thr > thr_prev) begin
          thr = thr_prev;
          rate = rate_prev;
        end
        return close_search(thr, rate, STATUS_CROSSED);
      end
    end
    thr_prev = thr;
    rate_prev = rate;
    rate_prev_ok = 1'b1;
    if (in_scan) thr = thr + scan_step_cfg;
    else if (rate > rate_goal_cfg) begin
      if (thr != 0) thr = thr - 1'b1;
    end else if (thr != THR_MAX) begin
      thr = thr + 1'b1;
    end
    thr_now = thr;
    res.next_threshold = thr;
    res.measured_rate = rate;
    res.status = STATUS_CONTINUE;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < 100)
      $display("result %0d: %s is %0d, predicted %0d", results_taken, what, got, want);
    mismatch_count++;
  endtask

  // Driver: one item in flight, a random gap after each accepted item.
  always @(negedge clk) begin
    if (!rst && !(in_valid && items_accepted != items_offered)) begin
      if (send_wait != 0) begin
        send_wait = send_wait - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_data <= pending_items.pop_front();
        in_valid <= 1'b1;
        items_offered = items_offered + 1;
        send_wait = send_quiet ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off that lets the block back up into its input.
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left = hold_left - 1;
      end else if (!hold_done && results_taken == 200) begin
        hold_left = 400;
        hold_done = 1'b1;
      end
    end
  end

  // Receiver: a random stall after each result.
  always @(negedge clk) begin
    if (!rst) begin
      if (results_taken != results_counted) begin
        results_counted = results_taken;
        take_wait = take_quiet ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) take_quiet = !take_quiet;
      end
      if (take_wait != 0) begin
        take_wait = take_wait - 1;
        out_ready <= 1'b0;
      end else if (hold_left != 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        results_due.push_back(next_search_result(in_data));
        items_accepted = items_accepted + 1;
      end
      if (out_valid && out_ready) begin
        results_taken = results_taken + 1;
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing predicted, threshold",
                          32'(out_data.next_threshold), '0);
        end else begin
          due_result = results_due.pop_front();
          if (out_data.next_threshold !== due_result.next_threshold)
            report_mismatch("next_threshold", 32'(out_data.next_threshold),
                            32'(due_result.next_threshold));
          if (out_data.measured_rate !== due_result.measured_rate)
            report_mismatch("measured_rate", out_data.measured_rate,
                            due_result.measured_rate);
          if (out_data.status !== due_result.status)
            report_mismatch("status", 32'(out_data.status), 32'(due_result.status));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[threshold_rate_search] ERROR");
      $finish;
    end
  end

  task automatic put_item(input logic [31:0] events, input logic [31:0] ticks);
    trs_in_t w;
    w.event_count = events;
    w.time_count = ticks;
    pending_items.push_back(w);
    items_queued++;
  endtask

  // Returns at a falling edge once every queued item has produced its result.
  task automatic drain();
    while (!(items_accepted == items_queued && results_due.size() == 0))
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_RATE_GOAL: rate_goal_cfg = value;
      REG_INITIAL_THR: initial_thr_cfg = value[THR_W-1:0];
      REG_SCAN_START: scan_start_cfg = value[THR_W-1:0];
      REG_SCAN_END: scan_end_cfg = value[THR_W-1:0];
      REG_SCAN_STEP: scan_step_cfg = value[THR_W-1:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  function automatic logic [THR_W-1:0] pick_thr(input int lo);
    case ($urandom_range(0, 3))
      0: return THR_W'(lo);
      1: return THR_MAX;
      default: return THR_W'($urandom_range(lo, 4095));
    endcase
  endfunction

  // Mode 0 puts every register at its low end, mode 1 at its high end, and any other mode picks random values.
  task automatic set_search_config(input int mode);
    logic [31:0] target;
    if (mode == 0) begin
      write_reg(REG_RATE_GOAL, '0);
      write_reg(REG_INITIAL_THR, '0);
      write_reg(REG_SCAN_START, '0);
      write_reg(REG_SCAN_END, '0);
      write_reg(REG_SCAN_STEP, 32'd1);
    end else if (mode == 1) begin
      write_reg(REG_RATE_GOAL, '1);
      write_reg(REG_INITIAL_THR, 32'(THR_MAX));
      write_reg(REG_SCAN_START, 32'(THR_MAX));
      write_reg(REG_SCAN_END, 32'(THR_MAX));
      write_reg(REG_SCAN_STEP, 32'(THR_MAX));
    end else begin
      case ($urandom_range(0, 7))
        0: target = '0;
        1: target = '1;
        default: target = $urandom_range(1, 2000000);
      endcase
      write_reg(REG_RATE_GOAL, target);
      write_reg(REG_INITIAL_THR, 32'(pick_thr(0)));
      write_reg(REG_SCAN_START, 32'(pick_thr(0)));
      write_reg(REG_SCAN_END, 32'(pick_thr(0)));
      write_reg(REG_SCAN_STEP, 32'(pick_thr(1)));
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [RATE_W-1:0] rate_above();
    logic [63:0] r;
    r = {32'd0, rate_goal_cfg} + 64'd1 +
        64'($urandom_range(0, rate_goal_cfg / 4 + 32'd100));
    return (r > 64'h0000_0000_FFFF_FFFF) ? RATE_SAT : r[31:0];
  endfunction

  function automatic logic [RATE_W-1:0] rate_below();
    if (rate_goal_cfg == 0) return 32'd1;
    return $urandom_range(1, rate_goal_cfg);
  endfunction

  // Builds a window whose measured rate lands near the requested one.
  task automatic put_rate(input logic [RATE_W-1:0] rate);
    logic [31:0] events;
    logic [63:0] ticks;
    events = $urandom_range(1, 1000);
    ticks = ({32'd0, events} * {38'd0, RATE_CLOCK_HZ}) / {32'd0, rate};
    if (ticks == 0) ticks = 64'd1;
    put_item(events, (ticks > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : ticks[31:0]);
  endtask

  task automatic put_silent();
    if ($urandom_range(0, 1) == 0) put_item('0, $urandom_range(1, 32'hFFFF_FFFF));
    else put_item(32'd1, $urandom_range(50000001, 32'hFFFF_FFFF));
  endtask

  task automatic put_side(input bit high);
    if (high) put_rate(rate_above());
    else put_rate(rate_below());
  endtask

  task automatic queue_episode();
    int kind;
    int n;
    bit high;
    kind = $urandom_range(0, 9);
    high = 1'($urandom_range(0, 1));
    n = $urandom_range(1, 8);
    if (kind <= 4) begin
      // Walk on one side of the target, then cross it.
      repeat (n) put_side(high);
      put_side(!high);
    end else if (kind <= 6) begin
      repeat ($urandom_range(1, 3)) put_side(high);
      repeat (3) put_silent();
    end else if (kind == 7) begin
      // Enough silent windows to start the coarse scan, then scan steps.
      repeat (15) put_silent();
      repeat ($urandom_range(1, 10)) begin
        if ($urandom_range(0, 5) == 0) put_side(high);
        else put_silent();
      end
    end else if (kind == 8) begin
      // Broken fallback: the silent run is cut short by a live window.
      put_side(high);
      repeat ($urandom_range(1, 2)) put_silent();
      put_side(1'($urandom_range(0, 1)));
    end else begin
      repeat ($urandom_range(1, 4))
        put_item($urandom, ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
    end
  endtask

  initial begin
    int phase_start;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // Register defaults: saturated rates, a crossing, then a fallback.
    put_item(32'd5, 32'd0);
    put_item(32'd0, 32'd0);
    put_item(32'hFFFF_FFFF, 32'd1);
    put_item(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    put_item(32'd1, 32'd100000);
    put_item(32'd1, 32'd100000);
    put_item(32'd0, 32'd12345);
    put_item(32'd1, 32'hFFFF_FFFF);
    put_item(32'd0, 32'hFFFF_FFFF);
    drain();

    // Scan entry wraps below zero; the first scan step already runs out.
    write_reg(REG_SCAN_START, 32'd50);
    write_reg(REG_SCAN_END, 32'd120);
    write_reg(REG_SCAN_STEP, 32'd100);
    write_reg(REG_INITIAL_THR, 32'(THR_MAX));
    cfg_we <= 1'b0;
    repeat (16) put_item(32'd0, 32'd777);
    // Restored at the top threshold, a low rate cannot step further up.
    put_item(32'd1, 32'd100000);
    drain();

    // Crossing restarts at threshold zero; a high rate cannot step below it.
    write_reg(REG_INITIAL_THR, '0);
    cfg_we <= 1'b0;
    put_item(32'd5, 32'd0);
    put_item(32'd5, 32'd0);
    drain();

    for (int phase = 0; phase < PHASES; phase++) begin
      drain();
      set_search_config(phase);
      phase_start = items_queued;
      while (items_queued - phase_start < PHASE_ITEMS) queue_episode();
    end

    drain();
    repeat (60) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("[threshold_rate_search] OK");
    end else begin
      $display("[threshold_rate_search] ERROR");
    end
    $finish;
  end

endmodule
